// File: hw/rtl/vpm_pkg.sv
// Shared types and constants for the vibrato pitch modulator.
// Holds the item structs, the configuration struct and the register indexes.
// No dependencies.
package vpm_pkg;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_NOTE   = 2'd1,
        KIND_TIED   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] note_scale;
        logic [2:0] octave_block;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pitch_offset;
        logic               offset_changed;
    } out_item_t;

    typedef struct packed {
        logic [7:0] start_delay;
        logic [7:0] mul_up;
        logic [7:0] mul_down;
        logic [7:0] len_up;
        logic [7:0] len_down;
        logic       initial_down;
        logic [4:0] step_period;
        logic       speaker_mode;
    } cfg_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_START_DELAY  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MUL_UP       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MUL_DOWN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEN_UP       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LEN_DOWN     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_DOWN = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_PERIOD  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEAKER_MODE = 3'd7;

    localparam logic [7:0] FRAC_HALF = 8'h80;

endpackage

// File: hw/rtl/vpm_cfg_regs.sv
// Configuration register file of the vibrato pitch modulator.
// Write-only registers addressed by index; depends on vpm_pkg.
module vpm_cfg_regs
    import vpm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_DELAY:  cfg_reg.start_delay  <= cfg_wdata;
                REG_MUL_UP:       cfg_reg.mul_up       <= cfg_wdata;
                REG_MUL_DOWN:     cfg_reg.mul_down     <= cfg_wdata;
                REG_LEN_UP:       cfg_reg.len_up       <= cfg_wdata;
                REG_LEN_DOWN:     cfg_reg.len_down     <= cfg_wdata;
                REG_INITIAL_DOWN: cfg_reg.initial_down <= cfg_wdata[0];
                REG_STEP_PERIOD:  cfg_reg.step_period  <= cfg_wdata[4:0];
                REG_SPEAKER_MODE: cfg_reg.speaker_mode <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/vpm_engine.sv
// Vibrato state and step logic: delay countdown, arming, slope turns and
// 8.8 accumulation into the pitch offset. Depends on vpm_pkg.
module vpm_engine
    import vpm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      item_en,
    input  in_item_t  item,
    output out_item_t result
);

    logic        armed_reg, armed_next;
    logic        falling_reg, falling_next;
    logic [7:0]  delay_count_reg, delay_count_next;
    logic [7:0]  half_count_reg, half_count_next;
    logic [7:0]  frac_acc_reg, frac_acc_next;
    logic [15:0] offset_acc_reg, offset_acc_next;
    logic [15:0] step_rise_reg, step_rise_next;
    logic [15:0] step_fall_reg, step_fall_next;
    logic [7:0]  scale_hold_reg, scale_hold_next;
    logic [2:0]  octave_hold_reg, octave_hold_next;

    logic        changed;
    logic [7:0]  delay_dec;
    logic [2:0]  shift_amt;
    logic [15:0] prod_up;
    logic [15:0] prod_down;
    logic [7:0]  half_w;
    logic        falling_w;
    logic [7:0]  frac_w;
    logic [15:0] rise_w;
    logic [15:0] fall_w;
    logic [8:0]  frac_sum;
    logic [8:0]  frac_diff;

    // The products are built ahead of the step so the arming path is flat.
    assign shift_amt = cfg.speaker_mode ? octave_hold_reg : 3'd0;
    assign prod_up   = (16'(cfg.mul_up) * 16'(scale_hold_reg)) >> shift_amt;
    assign prod_down = (16'(cfg.mul_down) * 16'(scale_hold_reg)) >> shift_amt;
    assign delay_dec = delay_count_reg - 8'd1;

    always_comb begin
        armed_next       = armed_reg;
        falling_next     = falling_reg;
        delay_count_next = delay_count_reg;
        half_count_next  = half_count_reg;
        frac_acc_next    = frac_acc_reg;
        offset_acc_next  = offset_acc_reg;
        step_rise_next   = step_rise_reg;
        step_fall_next   = step_fall_reg;
        scale_hold_next  = scale_hold_reg;
        octave_hold_next = octave_hold_reg;
        changed          = 1'b0;
        half_w           = half_count_reg;
        falling_w        = falling_reg;
        frac_w           = frac_acc_reg;
        rise_w           = step_rise_reg;
        fall_w           = step_fall_reg;
        frac_sum         = '0;
        frac_diff        = '0;

        unique case (kind_t'(item.kind))
            KIND_NOTE, KIND_TIED: begin
                scale_hold_next  = item.note_scale;
                octave_hold_next = item.octave_block;
                if (kind_t'(item.kind) == KIND_NOTE) begin
                    delay_count_next = cfg.start_delay;
                    offset_acc_next  = '0;
                    frac_acc_next    = FRAC_HALF;
                    armed_next       = 1'b0;
                end
            end
            KIND_TICK: begin
                if (cfg.start_delay != 8'd0) begin
                    delay_count_next = delay_dec;
                    if (delay_dec == 8'd0) begin
                        changed = 1'b1;
                        // The first expiry after a note fixes the steps.
                        if (!armed_reg) begin
                            rise_w    = prod_up;
                            fall_w    = prod_down;
                            half_w    = (cfg.initial_down ? cfg.len_down : cfg.len_up) >> 1;
                            frac_w    = FRAC_HALF;
                            falling_w = cfg.initial_down;
                        end
                        armed_next     = 1'b1;
                        step_rise_next = rise_w;
                        step_fall_next = fall_w;
                        delay_count_next = (cfg.step_period == 5'd0) ? 8'd1
                                                                     : 8'(cfg.step_period);
                        half_w = half_w - 8'd1;
                        if (half_w == 8'd0) begin
                            half_w    = falling_w ? cfg.len_up : cfg.len_down;
                            falling_w = !falling_w;
                            if (half_w == 8'd0) begin
                                half_w = 8'd1;
                            end
                        end
                        half_count_next = half_w;
                        falling_next    = falling_w;
                        if (!falling_w) begin
                            frac_sum        = {1'b0, frac_w} + {1'b0, rise_w[7:0]};
                            frac_acc_next   = frac_sum[7:0];
                            offset_acc_next = offset_acc_reg + {8'd0, rise_w[15:8]}
                                              + {15'd0, frac_sum[8]};
                        end else begin
                            frac_diff       = {1'b0, frac_w} - {1'b0, fall_w[7:0]};
                            frac_acc_next   = frac_diff[7:0];
                            offset_acc_next = offset_acc_reg - {8'd0, fall_w[15:8]}
                                              - {15'd0, frac_diff[8]};
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg       <= 1'b0;
            falling_reg     <= 1'b0;
            delay_count_reg <= '0;
            half_count_reg  <= '0;
            frac_acc_reg    <= FRAC_HALF;
            offset_acc_reg  <= '0;
            step_rise_reg   <= '0;
            step_fall_reg   <= '0;
            scale_hold_reg  <= '0;
            octave_hold_reg <= '0;
        end else if (item_en) begin
            armed_reg       <= armed_next;
            falling_reg     <= falling_next;
            delay_count_reg <= delay_count_next;
            half_count_reg  <= half_count_next;
            frac_acc_reg    <= frac_acc_next;
            offset_acc_reg  <= offset_acc_next;
            step_rise_reg   <= step_rise_next;
            step_fall_reg   <= step_fall_next;
            scale_hold_reg  <= scale_hold_next;
            octave_hold_reg <= octave_hold_next;
        end
    end

    assign result.pitch_offset   = offset_acc_next;
    assign result.offset_changed = changed;

endmodule

// File: hw/rtl/vibrato_pitch_modulator_core.sv
// Vibrato pitch modulator, top level: input register, step engine and result register.
// Depends on vpm_pkg, vpm_cfg_regs and vpm_engine.
//
// Each accepted item (tick, new note, tied note or unused kind) yields exactly one
// result item carrying the pitch offset after that item and a flag set when a tick
// made a vibrato step. The block takes one item per clock cycle while its result
// register is free or being taken, limited by the single step stage between its
// input and result registers; a result is offered once its item has passed both.
// Registers must be written through the configuration port only while no item is
// in flight; the block itself does not enforce this.
module vibrato_pitch_modulator_core
    import vpm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t      cfg;
    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t eng_out;
    logic      advance;

    // An item moves into the result register whenever that register is free or
    // being emptied in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    vpm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vpm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item_en (advance),
        .item    (in_reg),
        .result  (eng_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= eng_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item did not reach the input register");

    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result register not valid after an item advanced");

    a_note_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && kind_t'(in_reg.kind) != KIND_TICK) |-> !eng_out.offset_changed)
        else $error("non-tick item reported a vibrato step");

    a_note_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && kind_t'(in_reg.kind) == KIND_NOTE) |-> eng_out.pitch_offset == 16'sd0)
        else $error("new note did not clear the pitch offset");

endmodule
